@@ src/cis_pkg.sv @@
// ----------------------------------------------------------------------------
// CBOR item scanner package
// Shared types and constants for the scanner controller and datapath.
// ----------------------------------------------------------------------------
package cis_pkg;

   typedef enum logic [1:0] {
      PH_HEAD,
      PH_ARG,
      PH_PAYLOAD
   } phase_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_EVAL,
      CTL_POP,
      CTL_SEND
   } ctl_state_type;

   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_TAG   = 3'd1;
   localparam logic [2:0] ERR_AI    = 3'd2;
   localparam logic [2:0] ERR_DEEP  = 3'd3;
   localparam logic [2:0] ERR_TRUNC = 3'd4;

   localparam logic [2:0] MAJ_UINT  = 3'd0;
   localparam logic [2:0] MAJ_NINT  = 3'd1;
   localparam logic [2:0] MAJ_BYTES = 3'd2;
   localparam logic [2:0] MAJ_TEXT  = 3'd3;
   localparam logic [2:0] MAJ_ARRAY = 3'd4;
   localparam logic [2:0] MAJ_MAP   = 3'd5;
   localparam logic [2:0] MAJ_TAG   = 3'd6;
   localparam logic [2:0] MAJ_SPEC  = 3'd7;

   localparam logic [7:0] HEAD_NULL  = 8'hf6;
   localparam logic [7:0] HEAD_FALSE = 8'hf4;
   localparam logic [7:0] HEAD_TRUE  = 8'hf5;
   localparam logic [4:0] AI_ONE     = 5'd24;
   localparam logic [4:0] AI_EIGHT   = 5'd27;
   localparam logic [4:0] AI_BAD     = 5'd28;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  head_major;
      logic [2:0]  value_class;
      logic [63:0] argument;
      logic        head_done;
      logic        payload_byte;
      logic        item_done;
      logic        top_done;
      logic [4:0]  nest_depth;
      logic [2:0]  error_code;
   } rsp_type;

   typedef struct packed {
      logic eval;
      logic pop;
   } cmd_type;

   typedef struct packed {
      logic pop_needed;
   } sts_type;

   function automatic logic [2:0] class_of(input logic [7:0] h);
      logic [2:0] c;
      case (h[7:5])
         MAJ_UINT, MAJ_NINT: c = 3'd0;
         MAJ_BYTES:          c = 3'd1;
         MAJ_TEXT:           c = 3'd2;
         MAJ_ARRAY:          c = 3'd3;
         MAJ_MAP:            c = 3'd4;
         MAJ_SPEC: begin
            if (h == HEAD_NULL) c = 3'd5;
            else if (h == HEAD_FALSE || h == HEAD_TRUE) c = 3'd6;
            else c = 3'd7;
         end
         default:            c = 3'd7;
      endcase
      return c;
   endfunction

endpackage

@@ src/cis_stream_if.sv @@
// ----------------------------------------------------------------------------
// CBOR item scanner stream interface
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface cis_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ src/cbor_item_scanner.sv @@
// ----------------------------------------------------------------------------
// CBOR item scanner
// Walks a CBOR message one byte per item and reports each byte's decoding.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// req       in   data_byte, last_byte
// rsp       out  head_major, value_class, argument, flags, nest_depth, error
//
// A byte is accepted and then evaluated.
// A byte that completes an item inside a container then updates the stack
// level by level, closing each container that it completes and counting down
// the parent that stays open, if any.
// The next byte may be taken in the cycle its predecessor's result is taken.
// Reset is synchronous and returns the scanner to expecting a head byte.
// ----------------------------------------------------------------------------
module cbor_item_scanner #(
   parameter int MAX_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   cis_stream_if.sink   req_chan,
   cis_stream_if.source rsp_chan
);
   import cis_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    in_ready;
   logic    load;

   assign req_chan.ready = in_ready;
   assign load = req_chan.valid && in_ready;

   cis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (in_ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cis_datapath #(.MAX_DEPTH(MAX_DEPTH)) u_datapath (
      .clock (clock),
      .reset (reset),
      .load  (load),
      .req   (req_chan.payload),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp_chan.payload)
   );
endmodule

@@ src/cis_ctrl.sv @@
// ----------------------------------------------------------------------------
// CBOR item scanner controller
// Sequences byte acceptance, evaluation, stack pops and result hand-off.
// ----------------------------------------------------------------------------
module cis_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   input  cis_pkg::sts_type  sts,
   output cis_pkg::cmd_type  cmd
);
   import cis_pkg::*;

   ctl_state_type state_ff, state_in;

   assign cmd = '{eval: (state_ff == CTL_EVAL), pop: (state_ff == CTL_POP)};

   always_ff @(posedge clock) begin
      if (reset) state_ff <= CTL_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            in_ready = !reset;
            if (in_valid && !reset) state_in = CTL_EVAL;
         end
         CTL_EVAL: begin
            state_in = sts.pop_needed ? CTL_POP : CTL_SEND;
         end
         CTL_POP: begin
            if (!sts.pop_needed) state_in = CTL_SEND;
         end
         CTL_SEND: begin
            out_valid = 1'b1;
            in_ready  = out_ready;
            if (out_ready) state_in = in_valid ? CTL_EVAL : CTL_IDLE;
         end
         default: state_in = CTL_IDLE;
      endcase
   end
endmodule

@@ src/cis_datapath.sv @@
// ----------------------------------------------------------------------------
// CBOR item scanner datapath
// Head decode, argument collection, payload skipping and the level stack.
// ----------------------------------------------------------------------------
module cis_datapath #(
   parameter int MAX_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  cis_pkg::req_type  req,
   input  cis_pkg::cmd_type  cmd,
   output cis_pkg::sts_type  sts,
   output cis_pkg::rsp_type  rsp
);
   import cis_pkg::*;

   localparam int LW = $clog2(MAX_DEPTH + 1);
   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   logic [63:0] stack_mem [MAX_DEPTH];

   req_type     req_ff;
   phase_type   phase_ff, phase_in;
   logic [3:0]  left_ff, left_in;
   logic [63:0] acc_ff, acc_in;
   logic [7:0]  head_ff, head_in;
   logic [63:0] content_ff, content_in;
   logic [LW-1:0] open_ff, open_in;
   logic [2:0]  sticky_ff, sticky_in;
   logic        pop_ff, pop_in;
   logic        last_ff, last_in;
   rsp_type     rsp_ff, rsp_in;
   logic [63:0] top_ff, top_in;
   logic [63:0] below_ff;

   logic        push_en;

   logic [7:0]  d;
   logic [63:0] arg_v;
   logic        hc;
   logic        ic;
   logic [63:0] cnt;
   logic [63:0] acc_next;
   logic [2:0]  err;

   assign d       = req_ff.data_byte;
   assign sts.pop_needed = pop_in;
   assign rsp     = rsp_ff;

   function automatic logic [2:0] head_ff_sel(input phase_type ph, input logic [7:0] db,
                                              input logic [7:0] hh);
      return (ph == PH_HEAD) ? db[7:5] : hh[7:5];
   endfunction

   always_ff @(posedge clock) begin
      if (load) req_ff <= req;
      if (push_en && open_ff != '0) stack_mem[AW'(open_ff - LW'(1))] <= top_ff;
      if (push_en) below_ff <= top_ff;
      else below_ff <= stack_mem[AW'(open_in - LW'(2))];
      rsp_ff <= rsp_in;
      acc_ff <= acc_in;
      content_ff <= content_in;
      head_ff <= head_in;
      left_ff <= left_in;
      top_ff <= top_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEAD;
         open_ff   <= '0;
         sticky_ff <= ERR_NONE;
         pop_ff    <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         open_ff   <= open_in;
         sticky_ff <= sticky_in;
         pop_ff    <= pop_in;
         last_ff   <= last_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      left_in    = left_ff;
      acc_in     = acc_ff;
      head_in    = head_ff;
      content_in = content_ff;
      open_in    = open_ff;
      sticky_in  = sticky_ff;
      pop_in     = pop_ff;
      last_in    = last_ff;
      rsp_in     = rsp_ff;
      top_in     = top_ff;
      push_en    = 1'b0;
      hc         = 1'b0;
      ic         = 1'b0;
      arg_v      = '0;
      err        = ERR_NONE;
      cnt        = '0;
      acc_next   = {acc_ff[55:0], d};

      if (reset) begin
         left_in    = '0;
         acc_in     = '0;
         head_in    = '0;
         content_in = '0;
      end else if (cmd.eval) begin
         rsp_in  = '0;
         last_in = req_ff.last_byte;
         if (sticky_ff != ERR_NONE) begin
            err = sticky_ff;
         end else if (phase_ff == PH_HEAD) begin
            head_in = d;
            rsp_in.head_major  = d[7:5];
            rsp_in.value_class = class_of(d);
            if (d[7:5] == MAJ_TAG) begin
               err = ERR_TAG;
            end else if (d[7:5] == MAJ_SPEC) begin
               arg_v = {59'd0, d[4:0]};
               rsp_in.head_done = 1'b1;
               ic = 1'b1;
            end else if (d[4:0] >= AI_BAD) begin
               err = ERR_AI;
            end else if (d[4:0] < AI_ONE) begin
               hc = 1'b1;
               arg_v = {59'd0, d[4:0]};
            end else begin
               left_in  = 4'(4'd1 << (d[1:0]));
               acc_in   = '0;
               phase_in = PH_ARG;
            end
         end else if (phase_ff == PH_ARG) begin
            rsp_in.head_major  = head_ff[7:5];
            rsp_in.value_class = class_of(head_ff);
            acc_in = acc_next;
            if (left_ff <= 4'd1) begin
               left_in  = '0;
               phase_in = PH_HEAD;
               hc    = 1'b1;
               arg_v = acc_next;
            end else begin
               left_in = left_ff - 4'd1;
            end
         end else begin
            rsp_in.head_major   = head_ff[7:5];
            rsp_in.value_class  = class_of(head_ff);
            rsp_in.payload_byte = 1'b1;
            if (content_ff <= 64'd1) begin
               content_in = '0;
               phase_in   = PH_HEAD;
               ic = 1'b1;
            end else begin
               content_in = content_ff - 64'd1;
            end
         end

         if (hc) begin
            rsp_in.head_done = 1'b1;
            rsp_in.argument  = arg_v;
            case (head_ff_sel(phase_ff, d, head_ff))
               MAJ_UINT, MAJ_NINT: ic = 1'b1;
               MAJ_BYTES, MAJ_TEXT: begin
                  if (arg_v == 64'd0) ic = 1'b1;
                  else begin
                     content_in = arg_v;
                     phase_in   = PH_PAYLOAD;
                  end
               end
               default: begin
                  if (head_ff_sel(phase_ff, d, head_ff) == MAJ_MAP)
                     cnt = arg_v[63] ? '1 : {arg_v[62:0], 1'b0};
                  else
                     cnt = arg_v;
                  if (cnt == 64'd0) ic = 1'b1;
                  else if (open_ff >= LW'(MAX_DEPTH)) err = ERR_DEEP;
                  else begin
                     push_en  = 1'b1;
                     top_in   = cnt;
                     open_in  = open_ff + LW'(1);
                  end
               end
            endcase
         end
         if (rsp_in.head_done && hc == 1'b0 && sticky_ff == ERR_NONE) begin
            rsp_in.argument = arg_v;
         end

         if (ic && err == ERR_NONE) begin
            rsp_in.item_done = 1'b1;
            if (open_ff == '0) rsp_in.top_done = 1'b1;
            else pop_in = 1'b1;
         end

         if (sticky_ff == ERR_NONE && err != ERR_NONE) begin
            rsp_in.argument     = '0;
            rsp_in.head_done    = 1'b0;
            rsp_in.payload_byte = 1'b0;
            rsp_in.item_done    = 1'b0;
            rsp_in.top_done     = 1'b0;
         end
         rsp_in.error_code = err;
         if (!req_ff.last_byte && err != ERR_NONE) sticky_in = err;
         if (!pop_in) begin
            if (req_ff.last_byte) begin
               if (err == ERR_NONE && (phase_in != PH_HEAD || open_in != '0))
                  rsp_in.error_code = ERR_TRUNC;
               phase_in   = PH_HEAD;
               left_in    = '0;
               acc_in     = '0;
               head_in    = '0;
               content_in = '0;
               open_in    = '0;
               sticky_in  = ERR_NONE;
            end
            rsp_in.nest_depth = 5'(open_in);
         end
      end else if (cmd.pop) begin
         if (top_ff == 64'd1) begin
            open_in = open_ff - LW'(1);
            top_in  = below_ff;
            if (open_ff == LW'(1)) begin
               rsp_in.top_done = 1'b1;
               pop_in = 1'b0;
            end
         end else begin
            top_in = top_ff - 64'd1;
            pop_in = 1'b0;
         end
         if (!pop_in) begin
            if (last_ff) begin
               if (rsp_in.error_code == ERR_NONE &&
                   (phase_ff != PH_HEAD || open_in != '0))
                  rsp_in.error_code = ERR_TRUNC;
               phase_in   = PH_HEAD;
               left_in    = '0;
               acc_in     = '0;
               head_in    = '0;
               content_in = '0;
               open_in    = '0;
               sticky_in  = ERR_NONE;
            end
            rsp_in.nest_depth = 5'(open_in);
         end
      end
   end
endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CBOR item scanner testbench
// Feeds whole CBOR messages, well-formed, cut short and noisy, one byte per
// item with random sender gaps and receiver stalls, and checks every result
// against a scanner walk kept in the testbench.
// ----------------------------------------------------------------------------
module tb;
   import cis_pkg::*;

   localparam int STACK_LEVELS = 16;
   localparam int IDLE_LIMIT = 2000;

   logic clock;
   logic reset;

   cis_stream_if #(.payload_type(req_type)) req_if ();
   cis_stream_if #(.payload_type(rsp_type)) rsp_if ();

   cbor_item_scanner #(.MAX_DEPTH(STACK_LEVELS)) uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if.sink),
      .rsp_chan(rsp_if.source)
   );

   req_type    pending_bytes[$];
   rsp_type    expected_rsp[$];
   logic [7:0] msg_bytes[$];

   phase_type   scan_phase;
   int          arg_left;
   logic [63:0] arg_acc;
   logic [7:0]  held_head;
   logic [63:0] content_left;
   logic [63:0] level_left[STACK_LEVELS];
   int          open_levels;
   logic [2:0]  held_error;

   int failures;
   int bytes_sent;
   int results_seen;
   int messages;
   int error_results;
   int idle_cycles;
   int gap_left;
   int burst_left;
   int stall_left;
   int cycle_count;
   rsp_type predicted;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic reset_scan();
      scan_phase = PH_HEAD;
      arg_left = 0;
      arg_acc = '0;
      held_head = '0;
      content_left = '0;
      open_levels = 0;
      held_error = ERR_NONE;
   endtask

   task automatic close_item(inout rsp_type o);
      int t;
      o.item_done = 1'b1;
      while (1) begin
         if (open_levels == 0) begin
            o.top_done = 1'b1;
            break;
         end
         t = open_levels - 1;
         level_left[t] = level_left[t] - 1;
         if (level_left[t] != 0) break;
         open_levels = t;
      end
   endtask

   task automatic finish_head(input logic [63:0] a, inout rsp_type o);
      logic [2:0]  mj;
      logic [63:0] count;
      mj = held_head[7:5];
      o.head_done = 1'b1;
      o.argument = a;
      if (mj == MAJ_UINT || mj == MAJ_NINT) begin
         close_item(o);
      end else if (mj == MAJ_BYTES || mj == MAJ_TEXT) begin
         if (a == 0) begin
            close_item(o);
         end else begin
            content_left = a;
            scan_phase = PH_PAYLOAD;
         end
      end else begin
         if (mj == MAJ_MAP) count = a[63] ? '1 : (a << 1);
         else count = a;
         if (count == 0) begin
            close_item(o);
         end else if (open_levels >= STACK_LEVELS) begin
            o.error_code = ERR_DEEP;
         end else begin
            level_left[open_levels] = count;
            open_levels++;
         end
      end
   endtask

   task automatic scan_byte(input req_type r, output rsp_type o);
      logic [7:0] d;
      d = r.data_byte;
      o = '0;
      if (held_error != ERR_NONE) begin
         o.error_code = held_error;
      end else if (scan_phase == PH_HEAD) begin
         held_head = d;
         o.head_major = d[7:5];
         o.value_class = class_of(d);
         if (d[7:5] == MAJ_TAG) begin
            o.error_code = ERR_TAG;
         end else if (d[7:5] == MAJ_SPEC) begin
            o.head_done = 1'b1;
            o.argument = 64'(d[4:0]);
            close_item(o);
         end else if (d[4:0] >= AI_BAD) begin
            o.error_code = ERR_AI;
         end else if (d[4:0] < AI_ONE) begin
            finish_head(64'(d[4:0]), o);
         end else begin
            arg_left = 1 << (d[4:0] - AI_ONE);
            arg_acc = '0;
            scan_phase = PH_ARG;
         end
      end else if (scan_phase == PH_ARG) begin
         o.head_major = held_head[7:5];
         o.value_class = class_of(held_head);
         arg_acc = {arg_acc[55:0], d};
         if (arg_left > 0) arg_left--;
         if (arg_left == 0) begin
            scan_phase = PH_HEAD;
            finish_head(arg_acc, o);
         end
      end else begin
         o.head_major = held_head[7:5];
         o.value_class = class_of(held_head);
         o.payload_byte = 1'b1;
         if (content_left > 0) content_left = content_left - 1;
         if (content_left == 0) begin
            scan_phase = PH_HEAD;
            close_item(o);
         end
      end
      if (held_error == ERR_NONE && o.error_code != ERR_NONE) begin
         o.argument = '0;
         o.head_done = 1'b0;
         o.payload_byte = 1'b0;
         o.item_done = 1'b0;
         o.top_done = 1'b0;
      end
      if (r.last_byte) begin
         if (o.error_code == ERR_NONE && (scan_phase != PH_HEAD || open_levels != 0))
            o.error_code = ERR_TRUNC;
         reset_scan();
      end else if (o.error_code != ERR_NONE) begin
         held_error = o.error_code;
      end
      o.nest_depth = open_levels[4:0];
   endtask

   task automatic emit(input logic [7:0] b);
      msg_bytes.insert(msg_bytes.size(), b);
   endtask

   task automatic flush_msg();
      req_type r;
      for (int i = 0; i < msg_bytes.size(); i++) begin
         r.data_byte = msg_bytes[i];
         r.last_byte = (i == msg_bytes.size() - 1);
         pending_bytes.insert(pending_bytes.size(), r);
      end
      if (msg_bytes.size() > 0) messages++;
      msg_bytes.delete();
   endtask

   task automatic put_head(input logic [2:0] mj, input logic [63:0] v);
      int nbytes;
      int ai;
      if (v < 24 && $urandom_range(0, 3) != 0) begin
         emit({mj, v[4:0]});
      end else begin
         if (v < 256) ai = $urandom_range(24, 27);
         else if (v < 65536) ai = $urandom_range(25, 27);
         else if (v < 64'h1_0000_0000) ai = $urandom_range(26, 27);
         else ai = 27;
         nbytes = 1 << (ai - 24);
         emit({mj, 5'(ai)});
         for (int i = nbytes - 1; i >= 0; i--) emit(v[8 * i +: 8]);
      end
   endtask

   function automatic logic [63:0] rand_arg();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: v = v % 24;
         1: v = 64'(v[7:0]);
         2: v = 64'(v[15:0]);
         3: v = 64'(v[31:0]);
         default: ;
      endcase
      return v;
   endfunction

   task automatic gen_value(input int depth);
      int kind;
      int n;
      kind = $urandom_range(0, 7);
      if (depth >= 4 && (kind == 4 || kind == 5)) kind = 0;
      case (kind)
         0, 1: put_head(3'(kind), rand_arg());
         2, 3: begin
            n = $urandom_range(0, 4);
            put_head(3'(kind), 64'(n));
            repeat (n) emit(8'($urandom));
         end
         4: begin
            n = $urandom_range(0, 3);
            put_head(MAJ_ARRAY, 64'(n));
            repeat (n) gen_value(depth + 1);
         end
         5: begin
            n = $urandom_range(0, 2);
            put_head(MAJ_MAP, 64'(n));
            repeat (2 * n) gen_value(depth + 1);
         end
         default: emit({MAJ_SPEC, 5'($urandom)});
      endcase
   endtask

   task automatic cmp_field(input string name, input logic [63:0] e, input logic [63:0] a);
      if (e !== a) begin
         $error("%s mismatch: expected %0h, actual %0h", name, e, a);
         failures++;
      end
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.payload <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            scan_byte(req_if.payload, predicted);
            expected_rsp.insert(expected_rsp.size(), predicted);
            bytes_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_if.valid <= 1'b1;
               req_if.payload <= pending_bytes.pop_front();
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stalls come and go in some stretches, and other stretches are calm.
   always @(posedge clock) begin
      cycle_count++;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (rsp_if.payload.error_code != ERR_NONE) error_results++;
            if (expected_rsp.size() == 0) begin
               $error("result arrived with no byte waiting for one");
               failures++;
            end else begin
               predicted = expected_rsp.pop_front();
               cmp_field("head_major", predicted.head_major, rsp_if.payload.head_major);
               cmp_field("value_class", predicted.value_class, rsp_if.payload.value_class);
               cmp_field("argument", predicted.argument, rsp_if.payload.argument);
               cmp_field("head_done", predicted.head_done, rsp_if.payload.head_done);
               cmp_field("payload_byte", predicted.payload_byte,
                         rsp_if.payload.payload_byte);
               cmp_field("item_done", predicted.item_done, rsp_if.payload.item_done);
               cmp_field("top_done", predicted.top_done, rsp_if.payload.top_done);
               cmp_field("nest_depth", predicted.nest_depth, rsp_if.payload.nest_depth);
               cmp_field("error_code", predicted.error_code, rsp_if.payload.error_code);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if ((cycle_count / 300) % 2 == 1 && $urandom_range(0, 5) == 0)
               stall_left = $urandom_range(1, 12);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT && (pending_bytes.size() > 0 || expected_rsp.size() > 0
                                        || req_if.valid)) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int kind;
      int cut;
      reset = 1'b1;
      reset_scan();

      // Directed messages: extremes, every major type, and the special cases.
      emit(8'h00); flush_msg();
      emit(8'h1b); repeat (8) emit(8'hff); flush_msg();
      emit(8'h3a); repeat (4) emit(8'h80); flush_msg();
      emit(HEAD_NULL); emit(HEAD_FALSE); emit(HEAD_TRUE); emit(8'hf7); emit(8'hfc);
      emit(8'hff); flush_msg();
      emit(8'h80); emit(8'ha0); emit(8'h40); emit(8'h60); flush_msg();
      emit(8'h82); emit(8'h01); emit(8'h61); emit(8'h41); flush_msg();
      emit(8'ha1); emit(8'h18); emit(8'h7f); emit(8'h42); emit(8'h00); emit(8'hff);
      flush_msg();
      emit(8'hc0); emit(8'h01); emit(8'h02); flush_msg();
      emit(8'h1c); emit(8'h00); flush_msg();
      emit(8'h5f); flush_msg();
      repeat (17) emit(8'h81);
      emit(8'h00); flush_msg();
      emit(8'hbb); emit(8'h80); repeat (7) emit(8'h00); emit(8'h01); emit(8'h02);
      flush_msg();
      emit(8'h19); emit(8'h01); flush_msg();
      emit(8'h83); emit(8'h82); flush_msg();

      while (pending_bytes.size() < 400) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            repeat ($urandom_range(1, 3)) gen_value(0);
         end else if (kind == 6) begin
            gen_value(0);
            gen_value(0);
            cut = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
         end else if (kind == 7) begin
            repeat ($urandom_range(1, 6)) emit(8'($urandom));
         end else if (kind == 8) begin
            repeat ($urandom_range(10, 18)) emit(8'h81);
            gen_value(4);
         end else begin
            put_head(MAJ_ARRAY, 64'd3);
            repeat (3) gen_value(1);
            emit(8'($urandom));
         end
         flush_msg();
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() > 0 || req_if.valid) @(posedge clock);
      while (expected_rsp.size() > 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Scanned %0d bytes in %0d messages; %0d results checked, %0d with errors.",
               bytes_sent, messages, results_seen, error_results);
      if (failures == 0 && expected_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/cis_pkg.sv
src/cis_stream_if.sv
src/cis_ctrl.sv
src/cis_datapath.sv
src/cbor_item_scanner.sv
verif/tb.sv
